// ===== rtl/mas_pkg.sv =====
// shared constants and controller/datapath interface types for the moving average smoother
package mas_pkg;

   localparam int WINDOW_MAX_DEFAULT  = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 24;
   localparam int WLEN_BITS           = 11;

   typedef struct packed {
      logic load;
      logic read_old;
      logic update;
      logic div_init;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic prime;
   } status_type;

endpackage

// ===== rtl/mas_ram.sv =====
// generic single write port, single read port ram with registered read data
module mas_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wen,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     ren,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem_ff[waddr] <= wdata;
      end
      if (ren) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mas_ctrl.sv =====
// controller state machine sequencing the moving average datapath
module mas_ctrl #(
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  mas_pkg::status_type status,
   output mas_pkg::cmd_type    cmd
);

   localparam int CNT_W = $clog2(SAMPLE_BITS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_UPDATE = 3'd2;
   localparam logic [2:0] S_INIT   = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.prime ? S_OUT : S_READ;
            end
         end
         S_READ: begin
            cmd.read_old = 1'b1;
            state_in     = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_INIT;
         end
         S_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(SAMPLE_BITS - 1)) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

endmodule

// ===== rtl/mas_dp.sv =====
// datapath: window ring, running sum and shift-subtract divider
module mas_dp #(
   parameter int WINDOW_MAX  = mas_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [mas_pkg::WLEN_BITS-1:0] csr_wdata,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   input  mas_pkg::cmd_type              cmd,
   output mas_pkg::status_type           status,
   output logic signed [SAMPLE_BITS-1:0] rsp_average
);

   localparam int PTR_W = $clog2(WINDOW_MAX);
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W = SAMPLE_BITS + LEN_W;
   localparam int CMP_W = (LEN_W > mas_pkg::WLEN_BITS) ? LEN_W + 1 : mas_pkg::WLEN_BITS + 1;

   logic [mas_pkg::WLEN_BITS-1:0] window_len_ff;
   logic                          primed_ff, primed_in;
   logic [PTR_W-1:0]              wp_ff, wp_in;
   logic [LEN_W-1:0]              fill_ff, fill_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] prime_ff, prime_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic signed [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [LEN_W-1:0]              rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0]        quo_ff, quo_in;
   logic                          neg_ff, neg_in;

   logic [LEN_W-1:0]              len;
   logic [CMP_W-1:0]              wlen_ext;
   logic signed [SUM_W:0]         prod;
   logic [LEN_W-1:0]              wp_inc;
   logic [SAMPLE_BITS-1:0]        ram_rdata;
   logic signed [SAMPLE_BITS-1:0] oldest;
   logic [SUM_W-1:0]              mag;
   logic [LEN_W:0]                trial;
   logic                          qbit;

   // effective window length: zero reads as one, large values clamp
   always_comb begin
      wlen_ext = CMP_W'(window_len_ff);
      if (window_len_ff == '0) begin
         len = LEN_W'(1);
      end else if (wlen_ext > CMP_W'(WINDOW_MAX)) begin
         len = LEN_W'(WINDOW_MAX);
      end else begin
         len = LEN_W'(window_len_ff);
      end
   end

   assign status.prime = req_restart || !primed_ff;
   assign prod         = $signed(req_sample) * $signed({1'b0, len});
   assign wp_inc       = LEN_W'(wp_ff) + 1'b1;
   assign oldest       = (fill_ff >= len) ? $signed(ram_rdata) : prime_ff;
   assign mag          = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign trial        = {rem_ff, quo_ff[SAMPLE_BITS-1]};
   assign qbit         = (trial >= {1'b0, len});

   mas_ram #(
      .WIDTH(SAMPLE_BITS),
      .DEPTH(WINDOW_MAX)
   ) u_ram (
      .clock(clock),
      .wen  (cmd.update),
      .waddr(wp_ff),
      .wdata(sample_ff),
      .ren  (cmd.read_old),
      .raddr(wp_ff),
      .rdata(ram_rdata)
   );

   always_comb begin
      primed_in = primed_ff;
      wp_in     = wp_ff;
      fill_in   = fill_ff;
      sum_in    = sum_ff;
      prime_in  = prime_ff;
      sample_in = sample_ff;
      avg_in    = avg_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      neg_in    = neg_ff;
      if (cmd.load) begin
         sample_in = req_sample;
         if (status.prime) begin
            prime_in  = req_sample;
            sum_in    = SUM_W'(prod);
            wp_in     = '0;
            fill_in   = '0;
            primed_in = 1'b1;
            avg_in    = req_sample;
         end else if (LEN_W'(wp_ff) >= len) begin
            wp_in = '0;
         end
      end
      if (cmd.update) begin
         wp_in  = (wp_inc >= len) ? '0 : PTR_W'(wp_inc);
         sum_in = sum_ff + SUM_W'(sample_ff) - SUM_W'(oldest);
         if (fill_ff < len) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      // quotient magnitude fits the sample width, so the top bits seed the remainder
      if (cmd.div_init) begin
         neg_in = sum_ff[SUM_W-1];
         rem_in = mag[SUM_W-1:SAMPLE_BITS];
         quo_in = mag[SAMPLE_BITS-1:0];
      end
      if (cmd.div_step) begin
         rem_in = qbit ? LEN_W'(trial - {1'b0, len}) : LEN_W'(trial);
         quo_in = {quo_ff[SAMPLE_BITS-2:0], qbit};
      end
      if (cmd.finish) begin
         avg_in = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);
      end
      if (csr_wen) begin
         primed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_len_ff <= mas_pkg::WLEN_BITS'(1);
         primed_ff     <= 1'b0;
         wp_ff         <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         prime_ff      <= '0;
      end else begin
         if (csr_wen) begin
            window_len_ff <= csr_wdata;
         end
         primed_ff <= primed_in;
         wp_ff     <= wp_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         prime_ff  <= prime_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      avg_ff    <= avg_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      neg_ff    <= neg_in;
   end

   assign rsp_average = avg_ff;

endmodule

// ===== rtl/moving_average_smoother_core.sv =====
// top level of the moving average smoother: controller plus datapath
// sequence: a priming transaction (first after reset, after a window write, or restart)
//   shows its result the cycle after acceptance; others pass read, update, divide, finish
// throughput: one transaction at a time, set by the one-bit-per-cycle divider;
//   the next is accepted once the result has been taken
// reset: synchronous; window length returns to 1, window unprimed, ring memory not cleared
module moving_average_smoother_core #(
   parameter int WINDOW_MAX  = mas_pkg::WINDOW_MAX_DEFAULT,
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wen,
   input  logic [mas_pkg::WLEN_BITS-1:0] csr_wdata,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   input  logic                          req_restart,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_average
);

   mas_pkg::cmd_type    cmd;
   mas_pkg::status_type status;

   mas_ctrl #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   mas_dp #(
      .WINDOW_MAX (WINDOW_MAX),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_sample (req_sample),
      .req_restart(req_restart),
      .cmd        (cmd),
      .status     (status),
      .rsp_average(rsp_average)
   );

endmodule

// ===== rtl/mas_checker.sv =====
// port-level assertions for the moving average smoother, bound to the top level
module mas_checker #(
   parameter int SAMPLE_BITS = mas_pkg::SAMPLE_BITS_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [SAMPLE_BITS-1:0] rsp_average
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_average))
      else $error("stalled result changed");

   // no new transaction while a result waits
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while result pending");

   // accepted transaction makes the block busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("not busy after accept");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind moving_average_smoother_core mas_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_mas_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_average(rsp_average)
);
